@@ sv/sliding_window_min_max_top_assert.svh @@
// Assertion macros used by the sliding window min/max back part.
// Expects aclk and aresetn in the scope of every use.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SWMM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/swmm_pkg.sv @@
// Shared types and constants for the sliding window min/max block.
// No dependencies; imported by the front, back and top modules of the block.
package swmm_pkg;

    localparam int TIME_W     = 48;
    localparam int DATA_W     = 32;
    localparam int BC_W       = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int DIV_CNT_W  = $clog2(TIME_W);

    localparam logic [DATA_W-1:0] ALL_ONES   = '1;
    localparam logic [BC_W-1:0]   BC_RESET   = BC_W'(16);
    localparam logic [DATA_W-1:0] IV_RESET   = DATA_W'(1000000);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TIME_W - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_US  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV_OLD,
        F_DIV_NEW,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CLEAR,
        B_SCAN,
        B_FOLD
    } back_state_t;

endpackage

@@ sv/swmm_fifo.sv @@
// Small command queue between the front and back parts.
// Depends on nothing but its parameters.
module swmm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg < CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= ptr_inc(wptr_reg);
            if (pop)  rptr_reg <= ptr_inc(rptr_reg);
            if (push && !pop)      count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= in_data;
    end

endmodule

@@ sv/swmm_front.sv @@
// Front part: config registers, input acceptance, bucket numbering.
// Uses swmm_pkg; one shared restoring divider, a bit per cycle.
module swmm_front #(
    parameter int MAX_BUCKETS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swmm_pkg::DATA_W-1:0]     cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swmm_pkg::TIME_W-1:0]     s_elapsed_us,
    input  logic [swmm_pkg::DATA_W-1:0]     s_sample,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output logic                            cmd_wrap,
    output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] cmd_slot_old,
    output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] cmd_slot_new,
    output logic [$clog2(MAX_BUCKETS + 1)-1:0] cmd_n,
    output logic [swmm_pkg::DATA_W-1:0]     cmd_sample
);
    import swmm_pkg::*;

    localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int N_W   = $clog2(MAX_BUCKETS + 1);

    front_state_t          state_reg, state_next;
    logic [BC_W-1:0]       bc_reg;
    logic [DATA_W-1:0]     iv_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [DATA_W-1:0]     sample_reg;
    logic [TIME_W-1:0]     dvd_reg;
    logic [DATA_W-1:0]     rem_reg;
    logic [TIME_W-1:0]     quo_reg;
    logic [IDX_W-1:0]      mod_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0]     abs_old_reg;
    logic [IDX_W-1:0]      slot_old_reg;

    logic                  accept;
    logic                  push;
    logic                  cfg_fire;
    logic                  div_step;
    logic                  div_last;
    logic [N_W-1:0]        n_eff;
    logic [DATA_W-1:0]     iv_eff;
    logic [DATA_W:0]       rem_sh;
    logic                  qbit;
    logic [DATA_W-1:0]     rem_new;
    logic [TIME_W-1:0]     quo_new;
    logic [IDX_W:0]        mod_sh;
    logic [IDX_W-1:0]      mod_new;
    logic [TIME_W:0]       abs_diff;

    // Effective config: zero count means one slot, clamp to capacity
    always_comb begin
        if (bc_reg == '0) begin
            n_eff = N_W'(1);
        end else if (32'(bc_reg) > MAX_BUCKETS) begin
            n_eff = N_W'(MAX_BUCKETS);
        end else begin
            n_eff = N_W'(bc_reg);
        end
        iv_eff = (iv_reg == '0) ? DATA_W'(1) : iv_reg;
    end

    // One restoring division step; quotient mod n tracked alongside
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[TIME_W-1]};
        qbit    = rem_sh >= {1'b0, iv_eff};
        rem_new = qbit ? DATA_W'(rem_sh - {1'b0, iv_eff}) : rem_sh[DATA_W-1:0];
        quo_new = {quo_reg[TIME_W-2:0], qbit};
        mod_sh  = {mod_reg, qbit};
        mod_new = (mod_sh >= (IDX_W+1)'(n_eff)) ? IDX_W'(mod_sh - (IDX_W+1)'(n_eff))
                                                : mod_sh[IDX_W-1:0];
        div_last = cnt_reg == DIV_LAST;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:    if (s_tvalid) state_next = F_DIV_OLD;
            F_DIV_OLD: if (div_last) state_next = F_DIV_NEW;
            F_DIV_NEW: if (div_last) state_next = F_PUSH;
            F_PUSH:    if (cmd_ready) state_next = F_IDLE;
            default:   state_next = F_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready = 1'b0;
        cmd_valid = 1'b0;
        div_step = 1'b0;
        case (state_reg)
            F_IDLE:    s_tready = 1'b1;
            F_DIV_OLD: div_step = 1'b1;
            F_DIV_NEW: div_step = 1'b1;
            F_PUSH:    cmd_valid = 1'b1;
            default:   s_tready = 1'b0;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;
    assign push      = cmd_valid && cmd_ready;

    // Whole window passed, or time went backwards (borrow out)
    assign abs_diff     = {1'b0, quo_reg} - {1'b0, abs_old_reg};
    assign cmd_wrap     = abs_diff[TIME_W] || (abs_diff[TIME_W-1:0] >= TIME_W'(n_eff));
    assign cmd_slot_new = mod_reg;
    assign cmd_slot_old = cmd_wrap ? mod_reg : slot_old_reg;
    assign cmd_n        = n_eff;
    assign cmd_sample   = sample_reg;

    // Control state and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            bc_reg        <= BC_RESET;
            iv_reg        <= IV_RESET;
            last_time_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_BUCKET_COUNT: bc_reg <= cfg_data[BC_W-1:0];
                    CFG_INTERVAL_US:  iv_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (push) last_time_reg <= now_reg;
        end
    end

    // Divider datapath: old time first, then the new one
    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg    <= s_elapsed_us;
            sample_reg <= s_sample;
            dvd_reg    <= last_time_reg;
            rem_reg    <= '0;
            quo_reg    <= '0;
            mod_reg    <= '0;
            cnt_reg    <= '0;
        end else if (div_step) begin
            if (div_last && state_reg == F_DIV_OLD) begin
                abs_old_reg  <= quo_new;
                slot_old_reg <= mod_new;
                dvd_reg      <= now_reg;
                rem_reg      <= '0;
                quo_reg      <= '0;
                mod_reg      <= '0;
                cnt_reg      <= '0;
            end else begin
                dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
                rem_reg <= rem_new;
                quo_reg <= quo_new;
                mod_reg <= mod_new;
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

endmodule

@@ sv/swmm_back.sv @@
// Back part: bucket ring, clearing walk, bound rescan, fold and result register.
// Uses swmm_pkg and the assertion macro header.
`include "sliding_window_min_max_top_assert.svh"

module swmm_back #(
    parameter int MAX_BUCKETS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic                            cmd_wrap,
    input  logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] cmd_slot_old,
    input  logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] cmd_slot_new,
    input  logic [$clog2(MAX_BUCKETS + 1)-1:0] cmd_n,
    input  logic [swmm_pkg::DATA_W-1:0]     cmd_sample,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swmm_pkg::DATA_W-1:0]     m_window_min,
    output logic [swmm_pkg::DATA_W-1:0]     m_window_max
);
    import swmm_pkg::*;

    localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int N_W   = $clog2(MAX_BUCKETS + 1);

    back_state_t        state_reg, state_next;
    logic [DATA_W-1:0]  bmin_reg [MAX_BUCKETS];
    logic [DATA_W-1:0]  bmax_reg [MAX_BUCKETS];
    logic [DATA_W-1:0]  run_min_reg;
    logic [DATA_W-1:0]  run_max_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   slot_new_reg;
    logic [N_W-1:0]     n_reg;
    logic [DATA_W-1:0]  sample_reg;
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_min_reg;
    logic [DATA_W-1:0]  out_max_reg;

    logic               pop;
    logic               clr_all;
    logic               clr_one;
    logic               run_init;
    logic               scan_en;
    logic               fold_fire;
    logic               out_free;
    logic               clear_done;
    logic               scan_done;
    logic [DATA_W-1:0]  rd_min;
    logic [DATA_W-1:0]  rd_max;
    logic [DATA_W-1:0]  fold_bmin;
    logic [DATA_W-1:0]  fold_bmax;
    logic [DATA_W-1:0]  fold_rmin;
    logic [DATA_W-1:0]  fold_rmax;

    // Next ring slot, wrapping at the slot count
    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s,
                                                  input logic [N_W-1:0] n);
        logic [N_W-1:0] s1;
        s1 = N_W'(s) + N_W'(1);
        return (s1 == n) ? '0 : IDX_W'(s1);
    endfunction

    assign rd_min     = bmin_reg[idx_reg];
    assign rd_max     = bmax_reg[idx_reg];
    assign out_free   = !out_valid_reg || m_tready;
    assign clear_done = idx_reg == slot_new_reg;
    assign scan_done  = (N_W'(idx_reg) + N_W'(1)) == n_reg;

    assign fold_bmin = (sample_reg < rd_min) ? sample_reg : rd_min;
    assign fold_bmax = (sample_reg > rd_max) ? sample_reg : rd_max;
    assign fold_rmin = (sample_reg < run_min_reg) ? sample_reg : run_min_reg;
    assign fold_rmax = (sample_reg > run_max_reg) ? sample_reg : run_max_reg;

    // Next state and slot pointer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    if (!cmd_wrap && cmd_slot_new != cmd_slot_old) begin
                        state_next = B_CLEAR;
                        idx_next   = slot_inc(cmd_slot_old, cmd_n);
                    end else begin
                        state_next = B_FOLD;
                        idx_next   = cmd_slot_new;
                    end
                end
            end
            B_CLEAR: begin
                if (clear_done) begin
                    state_next = B_SCAN;
                    idx_next   = '0;
                end else begin
                    idx_next = slot_inc(idx_reg, n_reg);
                end
            end
            B_SCAN: begin
                if (scan_done) begin
                    state_next = B_FOLD;
                    idx_next   = slot_new_reg;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            B_FOLD: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        pop       = 1'b0;
        clr_all   = 1'b0;
        clr_one   = 1'b0;
        run_init  = 1'b0;
        scan_en   = 1'b0;
        fold_fire = 1'b0;
        case (state_reg)
            B_IDLE: begin
                pop     = cmd_valid;
                clr_all = cmd_valid && cmd_wrap;
            end
            B_CLEAR: begin
                clr_one  = 1'b1;
                run_init = clear_done;
            end
            B_SCAN:  scan_en = 1'b1;
            B_FOLD:  fold_fire = out_free;
            default: pop = 1'b0;
        endcase
    end

    assign cmd_ready = pop;

    // Control registers and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fold_fire)     out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // Command latch and slot pointer
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (pop) begin
            slot_new_reg <= cmd_slot_new;
            n_reg        <= cmd_n;
            sample_reg   <= cmd_sample;
        end
        if (fold_fire) begin
            out_min_reg <= fold_rmin;
            out_max_reg <= fold_rmax;
        end
    end

    // Bucket ring
    always_ff @(posedge aclk) begin
        if (!aresetn || clr_all) begin
            for (int i = 0; i < MAX_BUCKETS; i++) begin
                bmin_reg[i] <= ALL_ONES;
                bmax_reg[i] <= '0;
            end
        end else if (clr_one) begin
            bmin_reg[idx_reg] <= ALL_ONES;
            bmax_reg[idx_reg] <= '0;
        end else if (fold_fire) begin
            bmin_reg[idx_reg] <= fold_bmin;
            bmax_reg[idx_reg] <= fold_bmax;
        end
    end

    // Window bounds
    always_ff @(posedge aclk) begin
        if (!aresetn || clr_all || run_init) begin
            run_min_reg <= ALL_ONES;
            run_max_reg <= '0;
        end else if (scan_en) begin
            if (rd_min < run_min_reg) run_min_reg <= rd_min;
            if (rd_max > run_max_reg) run_max_reg <= rd_max;
        end else if (fold_fire) begin
            run_min_reg <= fold_rmin;
            run_max_reg <= fold_rmax;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_window_min = out_min_reg;
    assign m_window_max = out_max_reg;

    // A result always holds at least its own sample
    `SWMM_ASSERT_SAME(a_result_ordered, m_tvalid, m_window_min <= m_window_max, "result min above max")
    // The walk and the rescan stay inside the slots in use
    `SWMM_ASSERT_SAME(a_idx_in_use, state_reg == B_CLEAR || state_reg == B_SCAN, N_W'(idx_reg) < n_reg, "slot pointer beyond count")
    // A fold always shows up at the result port
    `SWMM_ASSERT_NEXT(a_fold_delivers, fold_fire, m_tvalid, "fold without result")

endmodule

@@ sv/sliding_window_min_max_top.sv @@
// Top level of the sliding window min/max block: front, command queue, back.
// Uses swmm_pkg, swmm_front, swmm_fifo and swmm_back.
//
//  Channel  Dir  Handshake           Payload
//  s_       in   s_tvalid/s_tready   s_tdata: elapsed_us[47:0], sample[79:48]
//  m_       out  m_tvalid/m_tready   m_tdata: window_min[31:0], window_max[63:32]
//  cfg_     in   cfg_valid/cfg_ready cfg_index (0 bucket_count, 1 interval_us), cfg_data
//
//  The front takes a new item only after pushing the last one: one shared restoring
//  divider works out the old and the new bucket number a quotient bit per cycle.
//  The back folds each item into its slot after clearing the slots it moves over
//  and rescanning the slots in use when the ring moves on; a two-entry queue
//  overlaps the two. A waiting result holds the back in its fold; once the queue is
//  full the front waits to push and s_tready stays low. Reset clears the ring at once.
module sliding_window_min_max_top #(
    parameter int MAX_BUCKETS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [swmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swmm_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [79:0]                    s_tdata,   // elapsed_us[47:0], sample[79:48]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata    // window_min[31:0], window_max[63:32]
);
    import swmm_pkg::*;

    localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int N_W   = $clog2(MAX_BUCKETS + 1);
    localparam int CMD_W = 1 + 2 * IDX_W + N_W + DATA_W;

    logic              f_valid, f_ready;
    logic              f_wrap;
    logic [IDX_W-1:0]  f_slot_old, f_slot_new;
    logic [N_W-1:0]    f_n;
    logic [DATA_W-1:0] f_sample;
    logic              b_valid, b_ready;
    logic              b_wrap;
    logic [IDX_W-1:0]  b_slot_old, b_slot_new;
    logic [N_W-1:0]    b_n;
    logic [DATA_W-1:0] b_sample;
    logic [CMD_W-1:0]  q_in, q_out;
    logic [DATA_W-1:0] win_min, win_max;

    swmm_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_elapsed_us (s_tdata[TIME_W-1:0]),
        .s_sample     (s_tdata[TIME_W+DATA_W-1:TIME_W]),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd_wrap     (f_wrap),
        .cmd_slot_old (f_slot_old),
        .cmd_slot_new (f_slot_new),
        .cmd_n        (f_n),
        .cmd_sample   (f_sample)
    );

    assign q_in = {f_wrap, f_slot_old, f_slot_new, f_n, f_sample};

    swmm_fifo #(.W(CMD_W), .DEPTH(2)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    assign {b_wrap, b_slot_old, b_slot_new, b_n, b_sample} = q_out;

    swmm_back #(.MAX_BUCKETS(MAX_BUCKETS)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (b_valid),
        .cmd_ready    (b_ready),
        .cmd_wrap     (b_wrap),
        .cmd_slot_old (b_slot_old),
        .cmd_slot_new (b_slot_new),
        .cmd_n        (b_n),
        .cmd_sample   (b_sample),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_window_min (win_min),
        .m_window_max (win_max)
    );

    assign m_tdata = {win_max, win_min};

endmodule
